### rtl/qte_pkg.sv
// ----------------------------------------------------------------------------
// qte_pkg
// Shared types and constants for the quaternion to Euler angle converter.
// ----------------------------------------------------------------------------
package qte_pkg;

    // Angle accumulator: degrees with 16 fraction bits
    localparam int QTE_ZW = 26;
    typedef logic signed [QTE_ZW-1:0] t_zang;

    // Output angle fields: degrees with 7 fraction bits
    typedef logic signed [15:0] t_ang16;
    typedef logic signed [14:0] t_ang15;

    localparam t_zang  QTE_DEG90     = 26'sd5898240;
    localparam t_ang16 QTE_ROLL_LIM  = 16'sd23040;
    localparam t_ang15 QTE_PITCH_LIM = 15'sd11520;

    // Square root of a 61-bit radicand: one result bit per iteration
    localparam int QTE_RAD_W     = 61;
    localparam int QTE_SQ_STAGES = 31;

    // atan(2^-i) in degrees * 65536
    localparam t_zang QTE_ATAN [32] = '{
        26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945,
        26'sd234379,  26'sd117304,  26'sd58666,  26'sd29335,
        26'sd14668,   26'sd7334,    26'sd3667,   26'sd1833,
        26'sd917,     26'sd458,     26'sd229,    26'sd115,
        26'sd57,      26'sd29,      26'sd14,     26'sd7,
        26'sd4,       26'sd2,       26'sd1,      26'sd0,
        26'sd0,       26'sd0,       26'sd0,      26'sd0,
        26'sd0,       26'sd0,       26'sd0,      26'sd0
    };

endpackage

### rtl/qte_quat_if.sv
// ----------------------------------------------------------------------------
// qte_quat_if
// Input channel: one quaternion per transaction, valid/ready handshake.
// ----------------------------------------------------------------------------
interface qte_quat_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;

    modport source (output valid, output quat_w, output quat_x, output quat_y,
                    output quat_z, input ready);
    modport sink   (input valid, input quat_w, input quat_x, input quat_y,
                    input quat_z, output ready);
endinterface

### rtl/qte_euler_if.sv
// ----------------------------------------------------------------------------
// qte_euler_if
// Output channel: roll, pitch, yaw and clamp flag per transaction.
// ----------------------------------------------------------------------------
interface qte_euler_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] roll_deg;
    logic signed [14:0] pitch_deg;
    logic signed [15:0] yaw_deg;
    logic               pitch_clamped;

    modport source (output valid, output roll_deg, output pitch_deg, output yaw_deg,
                    output pitch_clamped, input ready);
    modport sink   (input valid, input roll_deg, input pitch_deg, input yaw_deg,
                    input pitch_clamped, output ready);
endinterface

### rtl/quaternion_to_euler_angles.sv
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles
// Converts a Q2.14 quaternion to roll, pitch and yaw in degrees * 128.
// ----------------------------------------------------------------------------
// Fully pipelined: one quaternion is accepted every clock cycle while the
// pipeline is not stalled. The stages are: products, sums, pitch radicand,
// a 31-stage bit-per-stage integer square root, vector pre-rotation, one
// stage per CORDIC step (16 by default) for all three angles in parallel,
// and the output rounding register. The whole pipeline advances together;
// it holds only while a finished result waits at the output and is not taken.
module quaternion_to_euler_angles
    import qte_pkg::*;
#(
    parameter int FRAC_BITS    = 14,
    parameter int CORDIC_STEPS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    qte_quat_if.sink     i_quat,
    qte_euler_if.source  o_euler
);

    localparam int BW  = (2*FRAC_BITS > 32) ? 2*FRAC_BITS : 32;
    localparam int CW  = BW + 4;
    localparam int SHR = (2*FRAC_BITS >= 30) ? 2*FRAC_BITS - 30 : 0;
    localparam int SHL = (2*FRAC_BITS < 30) ? 30 - 2*FRAC_BITS : 0;
    localparam int NS  = 3 + QTE_SQ_STAGES + 1 + CORDIC_STEPS + 1;

    typedef logic signed [CW-1:0]        t_cval;
    typedef logic [QTE_RAD_W-1:0]        t_rad;

    typedef struct packed {
        t_cval x;
        t_cval y;
        t_zang z;
        logic  zero;
    } t_vec;

    typedef struct packed {
        t_cval       rn;
        t_cval       rd;
        t_cval       yn;
        t_cval       yd;
        logic [29:0] m30;
        logic        sneg;
        logic        sclamp;
    } t_carry;

    // Vector pre-rotation into the right half plane
    function automatic t_vec prerot(input t_cval y, input t_cval x);
        t_vec v;
        v.zero = (x == '0) && (y == '0);
        v.x = x;
        v.y = y;
        v.z = '0;
        if (x < 0) begin
            if (y >= 0) begin
                v.x = y;
                v.y = -x;
                v.z = QTE_DEG90;
            end else begin
                v.x = -y;
                v.y = x;
                v.z = -QTE_DEG90;
            end
        end
        return v;
    endfunction

    // One vectoring CORDIC iteration
    function automatic t_vec cstep(input t_vec v, input int i);
        t_vec  o;
        t_cval dx;
        t_cval dy;
        o  = v;
        dx = v.y >>> i;
        dy = v.x >>> i;
        if (v.y >= 0) begin
            o.x = v.x + dx;
            o.y = v.y - dy;
            o.z = v.z + QTE_ATAN[i];
        end else begin
            o.x = v.x - dx;
            o.y = v.y + dy;
            o.z = v.z - QTE_ATAN[i];
        end
        return o;
    endfunction

    // Round degrees*65536 to degrees*128
    function automatic logic signed [16:0] to_q7(input t_zang z);
        t_zang t;
        t = (z + t_zang'(256)) >>> 9;
        return t[16:0];
    endfunction

    logic en;
    logic [NS-1:0] r_vld;
    logic [NS-1:0] n_vld;

    // Pipeline advances unless the output holds an untaken result
    assign en           = !r_vld[NS-1] || o_euler.ready;
    assign i_quat.ready = en;
    assign n_vld        = {r_vld[NS-2:0], i_quat.valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= n_vld;
        end
    end

    // Stage 1: products
    logic signed [31:0] r_wx, r_yz, r_xx, r_yy, r_wz, r_xy, r_zz, r_wy, r_zx;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_wx <= i_quat.quat_w * i_quat.quat_x;
            r_yz <= i_quat.quat_y * i_quat.quat_z;
            r_xx <= i_quat.quat_x * i_quat.quat_x;
            r_yy <= i_quat.quat_y * i_quat.quat_y;
            r_wz <= i_quat.quat_w * i_quat.quat_z;
            r_xy <= i_quat.quat_x * i_quat.quat_y;
            r_zz <= i_quat.quat_z * i_quat.quat_z;
            r_wy <= i_quat.quat_w * i_quat.quat_y;
            r_zx <= i_quat.quat_z * i_quat.quat_x;
        end
    end

    // Stage 2: numerators, denominators, pitch argument
    t_cval  one;
    t_cval  s;
    t_cval  sabs;
    t_cval  msh;
    t_carry n_c2;
    t_carry r_c2;

    always_comb begin
        one  = t_cval'(1) <<< (2*FRAC_BITS);
        s    = (t_cval'(r_wy) - t_cval'(r_zx)) <<< 1;
        sabs = (s < 0) ? -s : s;
        msh  = t_cval'((sabs >> SHR) << SHL);
        n_c2.rn     = (t_cval'(r_wx) + t_cval'(r_yz)) <<< 1;
        n_c2.rd     = one - ((t_cval'(r_xx) + t_cval'(r_yy)) <<< 1);
        n_c2.yn     = (t_cval'(r_wz) + t_cval'(r_xy)) <<< 1;
        n_c2.yd     = one - ((t_cval'(r_yy) + t_cval'(r_zz)) <<< 1);
        n_c2.m30    = msh[29:0];
        n_c2.sneg   = s < 0;
        n_c2.sclamp = (s >= one) || (s <= -one);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c2 <= n_c2;
        end
    end

    // Stage 3: radicand 2^60 - m30^2
    logic [59:0] sq;
    t_rad        r_rad;
    t_carry      r_c3;

    assign sq = 60'(r_c2.m30) * 60'(r_c2.m30);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rad <= (t_rad'(1) << 60) - t_rad'(sq);
            r_c3  <= r_c2;
        end
    end

    // Square root: one result bit per stage
    t_rad   r_sv [QTE_SQ_STAGES];
    t_rad   r_sr [QTE_SQ_STAGES];
    t_carry r_sc [QTE_SQ_STAGES];

    for (genvar j = 0; j < QTE_SQ_STAGES; j++) begin : g_sqrt
        t_rad   v_in;
        t_rad   r_in;
        t_carry c_in;
        t_rad   bitv;
        t_rad   trial;

        if (j == 0) begin : g_first
            assign v_in = r_rad;
            assign r_in = '0;
            assign c_in = r_c3;
        end else begin : g_next
            assign v_in = r_sv[j-1];
            assign r_in = r_sr[j-1];
            assign c_in = r_sc[j-1];
        end

        assign bitv  = t_rad'(1) << (60 - 2*j);
        assign trial = r_in + bitv;

        always_ff @(posedge i_clk) begin
            if (en) begin
                if (v_in >= trial) begin
                    r_sv[j] <= v_in - trial;
                    r_sr[j] <= (r_in >> 1) + bitv;
                end else begin
                    r_sv[j] <= v_in;
                    r_sr[j] <= r_in >> 1;
                end
                r_sc[j] <= c_in;
            end
        end
    end

    // Pre-rotation and CORDIC steps for the three angles
    t_vec r_roll  [CORDIC_STEPS+1];
    t_vec r_pitch [CORDIC_STEPS+1];
    t_vec r_yaw   [CORDIC_STEPS+1];
    logic r_neg   [CORDIC_STEPS+1];
    logic r_clamp [CORDIC_STEPS+1];

    t_carry cl;
    t_cval  py;
    t_cval  px;

    assign cl = r_sc[QTE_SQ_STAGES-1];
    assign py = cl.sneg ? -t_cval'(cl.m30) : t_cval'(cl.m30);
    assign px = t_cval'(r_sr[QTE_SQ_STAGES-1][30:0]);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_roll[0]  <= prerot(cl.rn, cl.rd);
            r_yaw[0]   <= prerot(cl.yn, cl.yd);
            r_pitch[0] <= prerot(py, px);
            r_neg[0]   <= cl.sneg;
            r_clamp[0] <= cl.sclamp;
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_roll[i+1]  <= cstep(r_roll[i], i);
                r_yaw[i+1]   <= cstep(r_yaw[i], i);
                r_pitch[i+1] <= cstep(r_pitch[i], i);
                r_neg[i+1]   <= r_neg[i];
                r_clamp[i+1] <= r_clamp[i];
            end
        end
    end

    // Output stage: rounding, clamping, pitch saturation
    t_vec               fr;
    t_vec               fp;
    t_vec               fy;
    logic signed [16:0] qr;
    logic signed [16:0] qp;
    logic signed [16:0] qy;
    t_ang16             n_roll;
    t_ang15             n_pitch;
    t_ang16             n_yaw;
    t_ang16             r_roll_o;
    t_ang15             r_pitch_o;
    t_ang16             r_yaw_o;
    logic               r_clamp_o;

    always_comb begin
        fr = r_roll[CORDIC_STEPS];
        fp = r_pitch[CORDIC_STEPS];
        fy = r_yaw[CORDIC_STEPS];
        qr = fr.zero ? '0 : to_q7(fr.z);
        qp = fp.zero ? '0 : to_q7(fp.z);
        qy = fy.zero ? '0 : to_q7(fy.z);

        if (qr > 17'(QTE_ROLL_LIM))       n_roll = QTE_ROLL_LIM;
        else if (qr < -17'(QTE_ROLL_LIM)) n_roll = -QTE_ROLL_LIM;
        else                              n_roll = qr[15:0];

        if (qy > 17'(QTE_ROLL_LIM))       n_yaw = QTE_ROLL_LIM;
        else if (qy < -17'(QTE_ROLL_LIM)) n_yaw = -QTE_ROLL_LIM;
        else                              n_yaw = qy[15:0];

        if (r_clamp[CORDIC_STEPS]) begin
            n_pitch = r_neg[CORDIC_STEPS] ? -QTE_PITCH_LIM : QTE_PITCH_LIM;
        end else if (qp > 17'(QTE_PITCH_LIM)) begin
            n_pitch = QTE_PITCH_LIM;
        end else if (qp < -17'(QTE_PITCH_LIM)) begin
            n_pitch = -QTE_PITCH_LIM;
        end else begin
            n_pitch = qp[14:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_roll_o  <= n_roll;
            r_pitch_o <= n_pitch;
            r_yaw_o   <= n_yaw;
            r_clamp_o <= r_clamp[CORDIC_STEPS];
        end
    end

    assign o_euler.valid         = r_vld[NS-1];
    assign o_euler.roll_deg      = r_roll_o;
    assign o_euler.pitch_deg     = r_pitch_o;
    assign o_euler.yaw_deg       = r_yaw_o;
    assign o_euler.pitch_clamped = r_clamp_o;

endmodule

### rtl/qte_checker.sv
// ----------------------------------------------------------------------------
// qte_checker
// Port-level checks for the quaternion to Euler angle converter.
// ----------------------------------------------------------------------------
module qte_checker
    import qte_pkg::*;
(
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_in_ready,
    input logic         i_out_valid,
    input logic         i_out_ready,
    input logic signed [15:0] i_roll,
    input logic signed [14:0] i_pitch,
    input logic signed [15:0] i_yaw,
    input logic         i_clamped
);

    // No result right after reset
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // Input is taken whenever no result is waiting
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_out_valid || i_out_ready) |-> i_in_ready)
        else $error("input stalled with free output");

    // Saturated pitch is exactly plus or minus ninety degrees
    a_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_clamped) |->
        (i_pitch == QTE_PITCH_LIM || i_pitch == -QTE_PITCH_LIM))
        else $error("clamped pitch not at ninety degrees");

    // Roll and yaw stay within half a turn
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_roll <= QTE_ROLL_LIM && i_roll >= -QTE_ROLL_LIM &&
                         i_yaw <= QTE_ROLL_LIM && i_yaw >= -QTE_ROLL_LIM))
        else $error("angle out of range");

    // A stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_roll) &&
        $stable(i_pitch) && $stable(i_yaw) && $stable(i_clamped)))
        else $error("stalled result changed");

endmodule

bind quaternion_to_euler_angles qte_checker u_qte_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_quat.ready),
    .i_out_valid (o_euler.valid),
    .i_out_ready (o_euler.ready),
    .i_roll      (o_euler.roll_deg),
    .i_pitch     (o_euler.pitch_deg),
    .i_yaw       (o_euler.yaw_deg),
    .i_clamped   (o_euler.pitch_clamped)
);
